// ===== hdl/bdt_pkg.sv =====
`default_nettype none

package bdt_pkg;

  // Status codes of a result
  typedef enum logic [2:0] {
    StatOk         = 3'd0,
    StatBadDate    = 3'd1,
    StatBadHour    = 3'd2,
    StatBadMinute  = 3'd3,
    StatBadSecond  = 3'd4,
    StatOutOfRange = 3'd5
  } status_e;

  // Granularity, low two bits of the mode
  typedef enum logic [1:0] {
    GranDay    = 2'd0,
    GranHour   = 2'd1,
    GranMinute = 2'd2,
    GranSecond = 2'd3
  } gran_e;

  localparam int unsigned ModeWidth = 3;
  localparam int unsigned ModeBackBit = 2;

  localparam logic [7:0] BcdCentury  = 8'h20;
  localparam logic [7:0] BcdYearMax  = 8'h99;
  localparam logic [7:0] BcdMonthMax = 8'h12;
  localparam logic [7:0] BcdHourMax  = 8'h23;
  localparam logic [7:0] BcdSixtyMax = 8'h59;
  localparam logic [7:0] BcdZero     = 8'h00;
  localparam logic [7:0] BcdOne      = 8'h01;
  localparam logic [3:0] DigitMax    = 4'd9;

  typedef struct packed {
    logic [7:0] century;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } stamp_t;

  function automatic logic bcd_ok(input logic [7:0] b);
    return (b[7:4] <= DigitMax) && (b[3:0] <= DigitMax);
  endfunction

  // Year divisible by four: even tens digit with units 0/4/8, odd tens with 2/6
  function automatic logic leap_year(input logic [7:0] yy);
    logic [3:0] u;
    u = yy[3:0];
    if (yy[4]) begin
      return (u == 4'd2) || (u == 4'd6);
    end
    return (u == 4'd0) || (u == 4'd4) || (u == 4'd8);
  endfunction

  // Days in a month, as BCD
  function automatic logic [7:0] month_len(input logic [7:0] mo, input logic [7:0] yy);
    if (mo == 8'h02) begin
      return leap_year(yy) ? 8'h29 : 8'h28;
    end
    if ((mo == 8'h04) || (mo == 8'h06) || (mo == 8'h09) || (mo == 8'h11)) begin
      return 8'h30;
    end
    return 8'h31;
  endfunction

  function automatic logic [7:0] bcd_inc(input logic [7:0] b);
    if (b[3:0] == DigitMax) begin
      return {b[7:4] + 4'd1, 4'd0};
    end
    return {b[7:4], b[3:0] + 4'd1};
  endfunction

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    if (b[3:0] == 4'd0) begin
      return {b[7:4] - 4'd1, DigitMax};
    end
    return {b[7:4], b[3:0] - 4'd1};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bcd_datetime_step.sv =====
// bcd_datetime_step: one BCD timestamp step (next/previous day, hour, minute, second).
// Three registered stages lie between input transfer and result valid: check, step, select.
// Throughput: one transfer per cycle while stall_o is low. Each stage loads when it is
// empty or the next loads, so stall_o rises only when stall_i backs up a full pipe.
// Reset: rst_ni asynchronous, active low; clears the stage valid bits only.
`default_nettype none

module bcd_datetime_step (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 stall_o,
  input  wire logic [bdt_pkg::ModeWidth-1:0]   mode_i,
  input  wire logic [7:0]                      century_bcd_i,
  input  wire logic [7:0]                      year_bcd_i,
  input  wire logic [7:0]                      month_bcd_i,
  input  wire logic [7:0]                      day_bcd_i,
  input  wire logic [7:0]                      hour_bcd_i,
  input  wire logic [7:0]                      minute_bcd_i,
  input  wire logic [7:0]                      second_bcd_i,
  output logic                                 valid_o,
  input  wire logic                            stall_i,
  output logic [2:0]                           status_o,
  output logic [7:0]                           century_out_o,
  output logic [7:0]                           year_out_o,
  output logic [7:0]                           month_out_o,
  output logic [7:0]                           day_out_o,
  output logic [7:0]                           hour_out_o,
  output logic [7:0]                           minute_out_o,
  output logic [7:0]                           second_out_o
);
  import bdt_pkg::*;

  // ---------------------------------------------------------------------------
  // Stall chain: a stage loads when it is empty or the next stage loads.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: validity checks on the fields the granularity uses.
  // BCD digits first, then the date, then hour, minute, second.
  // ---------------------------------------------------------------------------
  stamp_t  in_stamp;
  gran_e   in_gran;
  logic    digits_ok;
  logic    date_bad;
  status_e chk_d;

  assign in_stamp = '{century: century_bcd_i, year: year_bcd_i, month: month_bcd_i,
                      day: day_bcd_i, hour: hour_bcd_i, minute: minute_bcd_i,
                      second: second_bcd_i};
  assign in_gran  = gran_e'(mode_i[1:0]);

  always_comb begin
    digits_ok = bcd_ok(in_stamp.century) && bcd_ok(in_stamp.year) &&
                bcd_ok(in_stamp.month) && bcd_ok(in_stamp.day) &&
                (in_gran == GranDay || bcd_ok(in_stamp.hour)) &&
                (in_gran == GranDay || in_gran == GranHour || bcd_ok(in_stamp.minute)) &&
                (in_gran != GranSecond || bcd_ok(in_stamp.second));

    date_bad = (in_stamp.century != BcdCentury) || (in_stamp.month == BcdZero) ||
               (in_stamp.month > BcdMonthMax) || (in_stamp.day == BcdZero) ||
               (in_stamp.day > month_len(in_stamp.month, in_stamp.year));

    priority if (!digits_ok || date_bad) begin
      chk_d = StatBadDate;
    end else if (in_gran != GranDay && in_stamp.hour > BcdHourMax) begin
      chk_d = StatBadHour;
    end else if ((in_gran == GranMinute || in_gran == GranSecond) &&
                 in_stamp.minute > BcdSixtyMax) begin
      chk_d = StatBadMinute;
    end else if (in_gran == GranSecond && in_stamp.second > BcdSixtyMax) begin
      chk_d = StatBadSecond;
    end else begin
      chk_d = StatOk;
    end
  end

  logic [ModeWidth-1:0] s1_mode_q;
  stamp_t               s1_stamp_q;
  status_e              s1_chk_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mode_q  <= mode_i;
      s1_stamp_q <= in_stamp;
      s1_chk_q   <= chk_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per field, the stepped value and whether the step wraps
  // (and so carries or borrows into the next coarser field).
  // ---------------------------------------------------------------------------
  logic       s1_back;
  stamp_t     nxt_d;
  logic [5:0] wrap_d;   // second, minute, hour, day, month, year
  logic [7:0] mo_prev;

  assign s1_back = s1_mode_q[ModeBackBit];

  always_comb begin
    nxt_d         = s1_stamp_q;
    mo_prev       = (s1_stamp_q.month == BcdOne) ? BcdMonthMax : bcd_dec(s1_stamp_q.month);
    if (!s1_back) begin
      wrap_d[0] = s1_stamp_q.second == BcdSixtyMax;
      wrap_d[1] = s1_stamp_q.minute == BcdSixtyMax;
      wrap_d[2] = s1_stamp_q.hour == BcdHourMax;
      wrap_d[3] = s1_stamp_q.day == month_len(s1_stamp_q.month, s1_stamp_q.year);
      wrap_d[4] = s1_stamp_q.month == BcdMonthMax;
      wrap_d[5] = s1_stamp_q.year == BcdYearMax;
      nxt_d.second = wrap_d[0] ? BcdZero : bcd_inc(s1_stamp_q.second);
      nxt_d.minute = wrap_d[1] ? BcdZero : bcd_inc(s1_stamp_q.minute);
      nxt_d.hour   = wrap_d[2] ? BcdZero : bcd_inc(s1_stamp_q.hour);
      nxt_d.day    = wrap_d[3] ? BcdOne : bcd_inc(s1_stamp_q.day);
      nxt_d.month  = wrap_d[4] ? BcdOne : bcd_inc(s1_stamp_q.month);
      nxt_d.year   = bcd_inc(s1_stamp_q.year);
    end else begin
      wrap_d[0] = s1_stamp_q.second == BcdZero;
      wrap_d[1] = s1_stamp_q.minute == BcdZero;
      wrap_d[2] = s1_stamp_q.hour == BcdZero;
      wrap_d[3] = s1_stamp_q.day == BcdOne;
      wrap_d[4] = s1_stamp_q.month == BcdOne;
      wrap_d[5] = s1_stamp_q.year == BcdZero;
      nxt_d.second = wrap_d[0] ? BcdSixtyMax : bcd_dec(s1_stamp_q.second);
      nxt_d.minute = wrap_d[1] ? BcdSixtyMax : bcd_dec(s1_stamp_q.minute);
      nxt_d.hour   = wrap_d[2] ? BcdHourMax : bcd_dec(s1_stamp_q.hour);
      // Borrow from the month: last day of the previous month. The year only
      // changes with a December wrap, where the length is 31 anyway.
      nxt_d.day    = wrap_d[3] ? month_len(mo_prev, s1_stamp_q.year)
                               : bcd_dec(s1_stamp_q.day);
      nxt_d.month  = mo_prev;
      nxt_d.year   = bcd_dec(s1_stamp_q.year);
    end
  end

  gran_e   s2_gran_q;
  stamp_t  s2_stamp_q;
  stamp_t  s2_nxt_q;
  logic [5:0] s2_wrap_q;
  status_e s2_chk_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_gran_q  <= gran_e'(s1_mode_q[1:0]);
      s2_stamp_q <= s1_stamp_q;
      s2_nxt_q   <= nxt_d;
      s2_wrap_q  <= wrap_d;
      s2_chk_q   <= s1_chk_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: ripple the carry from the granularity field upward, flag a step
  // out of the century, and pick stepped or original bytes.
  // ---------------------------------------------------------------------------
  logic    step_min, step_hour, step_day, step_mon, step_year;
  logic    ok;
  status_e stat_d;
  stamp_t  res_d;

  always_comb begin
    step_min  = (s2_gran_q == GranMinute) || (s2_gran_q == GranSecond && s2_wrap_q[0]);
    step_hour = (s2_gran_q == GranHour) || (step_min && s2_wrap_q[1]);
    step_day  = (s2_gran_q == GranDay) || (step_hour && s2_wrap_q[2]);
    step_mon  = step_day && s2_wrap_q[3];
    step_year = step_mon && s2_wrap_q[4];

    priority if (s2_chk_q != StatOk) begin
      stat_d = s2_chk_q;
    end else if (step_year && s2_wrap_q[5]) begin
      stat_d = StatOutOfRange;
    end else begin
      stat_d = StatOk;
    end
    ok = stat_d == StatOk;

    res_d        = s2_stamp_q;
    if (ok) begin
      if (s2_gran_q == GranSecond) begin
        res_d.second = s2_nxt_q.second;
      end
      if (step_min) begin
        res_d.minute = s2_nxt_q.minute;
      end
      if (step_hour) begin
        res_d.hour = s2_nxt_q.hour;
      end
      if (step_day) begin
        res_d.day = s2_nxt_q.day;
      end
      if (step_mon) begin
        res_d.month = s2_nxt_q.month;
      end
      if (step_year) begin
        res_d.year = s2_nxt_q.year;
      end
    end
  end

  status_e s3_stat_q;
  stamp_t  s3_res_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_stat_q <= stat_d;
      s3_res_q  <= res_d;
    end
  end

  assign valid_o       = v3_q;
  assign status_o      = s3_stat_q;
  assign century_out_o = s3_res_q.century;
  assign year_out_o    = s3_res_q.year;
  assign month_out_o   = s3_res_q.month;
  assign day_out_o     = s3_res_q.day;
  assign hour_out_o    = s3_res_q.hour;
  assign minute_out_o  = s3_res_q.minute;
  assign second_out_o  = s3_res_q.second;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A good result always stays in the only accepted century.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == StatOk) |-> century_out_o == BcdCentury)
    else $error("ok result left the century");

  // A good result has a real month and a nonzero day.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == StatOk) |->
      (month_out_o != BcdZero && month_out_o <= BcdMonthMax && day_out_o != BcdZero))
    else $error("ok result holds a bad month or day");

  // Leaving the century is only possible from year 99 forward or year 00 back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == StatOutOfRange) |->
      (year_out_o == BcdYearMax || year_out_o == BcdZero))
    else $error("out of range flagged from a mid-century year");

  // A held result stays valid until it transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && stall_i) |=> v3_q)
    else $error("stalled result dropped");

endmodule

`default_nettype wire
